/* design/orlc_pkg.sv */
// Shared types and constants for the optical run-length code receiver.
`default_nettype none

package orlc_pkg;

   // Default values of the top-level parameters.
   localparam int AVG_LEN_DEFAULT   = 4;
   localparam int FRAME_LEN_DEFAULT = 128;

   // Field widths.
   localparam int POS_W   = 8;
   localparam int RUN_W   = 5;
   localparam int COUNT_W = 4;
   localparam int CODE_W  = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // Register reset values.
   localparam logic [CODE_W-1:0] CODE_MASK_RESET     = 8'd255;
   localparam logic [RUN_W-1:0]  RUN_THRESHOLD_RESET = 5'd5;
   localparam logic [POS_W-1:0]  WINDOW_START_RESET  = 8'd20;
   localparam logic [POS_W-1:0]  WINDOW_END_RESET    = 8'd80;

   // A nonzero code is only reported when this many bits were found.
   localparam logic [COUNT_W-1:0] VALID_BITS_LO = 4'd6;
   localparam logic [COUNT_W-1:0] VALID_BITS_HI = 4'd7;

   localparam logic [RUN_W-1:0]   RUN_MAX   = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CODE_MASK     = 2'd0,
      CSR_RUN_THRESHOLD = 2'd1,
      CSR_WINDOW_START  = 2'd2,
      CSR_WINDOW_END    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [CODE_W-1:0] code_mask;
      logic [RUN_W-1:0]  run_threshold;
      logic [POS_W-1:0]  window_start;
      logic [POS_W-1:0]  window_end;
   } cfg_type;

   typedef struct packed {
      logic [CODE_W-1:0]  light_code;
      logic [COUNT_W-1:0] bit_count;
   } result_type;

endpackage

`default_nettype wire

/* design/optical_run_length_code_receiver_core.sv */
// Top level of the optical run-length code receiver.
//
// The block takes one light-sensor sample per transfer on the req_ channel
// (req_sense_bit, req_frame_end) and returns one result per frame on the rsp_
// channel (rsp_light_code, rsp_bit_count). Only a sample marked as frame end
// produces a result; all other samples produce none.
// A transfer is first captured in an input register. When the sample is taken
// from there, the moving-average filter and the run-length decoder update their
// state and, on a frame end, the result register is loaded, which drives
// rsp_valid. One sample can be taken every cycle unless a frame-end sample is
// stalled; the single pass of filter and decoder logic between the two
// registers sets that rate.
// When the receiver holds rsp_ready low, the result waits in its register.
// Plain samples keep flowing; only a frame-end sample waits in the input
// register until the previous result has been taken, and req_ready drops then.
// The csr_ channel writes code_mask, run_threshold, window_start and
// window_end by index and is always ready; write it only while idle.
// Reset clears the filter window, the frame state and the valid bits of both
// pipeline registers and restores the CSR defaults. No clearing pass is needed.
`default_nettype none

module optical_run_length_code_receiver_core #(
   parameter int AVG_LEN   = orlc_pkg::AVG_LEN_DEFAULT,
   parameter int FRAME_LEN = orlc_pkg::FRAME_LEN_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_sense_bit,
   input  wire logic                                req_frame_end,

   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [orlc_pkg::CODE_W-1:0]              rsp_light_code,
   output logic [orlc_pkg::COUNT_W-1:0]             rsp_bit_count,

   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [orlc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [orlc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import orlc_pkg::*;

   // Configuration registers.
   cfg_type cfg_ff;

   // Input register.
   logic in_valid_ff;
   logic in_sense_ff;
   logic in_fend_ff;

   // Result register.
   logic               rsp_valid_ff;
   logic [CODE_W-1:0]  rsp_code_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   logic       fire;
   logic       active;
   logic       level;
   result_type result;

   // A sample is processed when it is present and, if it produces a result,
   // the result register is free or being emptied in this cycle.
   assign fire = in_valid_ff && (!in_fend_ff || !rsp_valid_ff || rsp_ready);

   assign req_ready = !in_valid_ff || fire;
   assign csr_ready = 1'b1;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_light_code = rsp_code_ff;
   assign rsp_bit_count  = rsp_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.code_mask     <= CODE_MASK_RESET;
         cfg_ff.run_threshold <= RUN_THRESHOLD_RESET;
         cfg_ff.window_start  <= WINDOW_START_RESET;
         cfg_ff.window_end    <= WINDOW_END_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_CODE_MASK:     cfg_ff.code_mask     <= csr_wdata;
            CSR_RUN_THRESHOLD: cfg_ff.run_threshold <= csr_wdata[RUN_W-1:0];
            CSR_WINDOW_START:  cfg_ff.window_start  <= csr_wdata;
            CSR_WINDOW_END:    cfg_ff.window_end    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_sense_ff <= req_sense_bit;
         in_fend_ff  <= req_frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && in_fend_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && in_fend_ff) begin
         rsp_code_ff  <= result.light_code;
         rsp_count_ff <= result.bit_count;
      end
   end

   // Samples past the frame length do not enter the filter.
   orlc_filter #(
      .AVG_LEN (AVG_LEN)
   ) u_filter (
      .clock  (clock),
      .reset  (reset),
      .enable (fire && active),
      .sample (in_sense_ff),
      .level  (level)
   );

   orlc_decoder #(
      .FRAME_LEN (FRAME_LEN)
   ) u_decoder (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .level     (level),
      .frame_end (in_fend_ff),
      .cfg       (cfg_ff),
      .active    (active),
      .result    (result)
   );

   // A new result only ever comes from a processed frame-end sample.
   a_result_from_frame_end : assert property (
      @(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fire && in_fend_ff)
   ) else $error("result appeared without a frame-end sample");

   // A nonzero code is reported only with six or seven bits found.
   a_code_needs_valid_count : assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_code_ff != '0) |->
         (rsp_count_ff == VALID_BITS_LO || rsp_count_ff == VALID_BITS_HI)
   ) else $error("nonzero code with invalid bit count");

   // A waiting sample keeps its contents until it is processed.
   a_input_held_while_stalled : assert property (
      @(posedge clock) disable iff (reset)
      (in_valid_ff && !fire) |=>
         (in_valid_ff && $stable(in_sense_ff) && $stable(in_fend_ff))
   ) else $error("stalled sample was lost or changed");

endmodule

`default_nettype wire

/* design/orlc_filter.sv */
// Moving-average filter with round-half-up decision over the last AVG_LEN samples.
`default_nettype none

module orlc_filter #(
   parameter int AVG_LEN = orlc_pkg::AVG_LEN_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic enable,
   input  wire logic sample,
   output logic      level
);
   localparam int SUM_W = $clog2(AVG_LEN + 1);
   localparam int CMP_W = SUM_W + 1;

   logic [AVG_LEN-1:0] window_ff;
   logic [AVG_LEN-1:0] window_in;
   logic [SUM_W-1:0]   sum;

   // The window seen by the decision includes the new sample.
   generate
      if (AVG_LEN == 1) begin : g_single
         assign window_in = sample;
      end else begin : g_shift
         assign window_in = {window_ff[AVG_LEN-2:0], sample};
      end
   endgenerate

   assign sum   = SUM_W'($countones(window_in));
   assign level = ({sum, 1'b0} >= CMP_W'(AVG_LEN));

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (enable) begin
         window_ff <= window_in;
      end
   end

endmodule

`default_nettype wire

/* design/orlc_decoder.sv */
// Frame position tracking and run-length bit decoder.
`default_nettype none

module orlc_decoder #(
   parameter int FRAME_LEN = orlc_pkg::FRAME_LEN_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                fire,
   input  wire logic                level,
   input  wire logic                frame_end,
   input  wire orlc_pkg::cfg_type   cfg,
   output logic                     active,
   output orlc_pkg::result_type     result
);
   import orlc_pkg::*;

   logic [POS_W-1:0]   frame_pos_ff, frame_pos_in;
   logic [RUN_W-1:0]   run_count_ff, run_count_in;
   logic               expected_ff, expected_in;
   logic [COUNT_W-1:0] bits_found_ff, bits_found_in;
   logic [CODE_W-1:0]  code_acc_ff, code_acc_in;

   logic               in_window;
   logic [RUN_W-1:0]   rc;
   logic               el;
   logic [COUNT_W-1:0] bf;
   logic [CODE_W-1:0]  ca;
   logic [2:0]         bit_idx;

   always_comb begin
      active    = (frame_pos_ff < POS_W'(FRAME_LEN));
      in_window = active && (frame_pos_ff >= cfg.window_start)
                         && (frame_pos_ff < cfg.window_end);
      rc      = run_count_ff;
      el      = expected_ff;
      bf      = bits_found_ff;
      ca      = code_acc_ff;
      bit_idx = ~bf[2:0];

      if (in_window) begin
         if (level == el) begin
            if (rc != RUN_MAX) begin
               rc = rc + RUN_W'(1);
            end
         end else begin
            rc = '0;
            el = level;
         end
         if (rc >= cfg.run_threshold) begin
            // Bits go in MSB first; only the first eight are kept.
            if (!bf[3]) begin
               ca[bit_idx] = ca[bit_idx] | el;
            end
            if (bf != COUNT_MAX) begin
               bf = bf + COUNT_W'(1);
            end
            el = ~el;
            rc = '0;
         end
      end

      result.light_code = (bf == VALID_BITS_LO || bf == VALID_BITS_HI) ?
                          (ca & cfg.code_mask) : '0;
      result.bit_count  = bf;

      frame_pos_in  = active ? frame_pos_ff + POS_W'(1) : frame_pos_ff;
      run_count_in  = rc;
      expected_in   = el;
      bits_found_in = bf;
      code_acc_in   = ca;
      if (frame_end) begin
         frame_pos_in  = '0;
         run_count_in  = '0;
         expected_in   = 1'b0;
         bits_found_in = '0;
         code_acc_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_pos_ff  <= '0;
         run_count_ff  <= '0;
         expected_ff   <= 1'b0;
         bits_found_ff <= '0;
         code_acc_ff   <= '0;
      end else if (fire) begin
         frame_pos_ff  <= frame_pos_in;
         run_count_ff  <= run_count_in;
         expected_ff   <= expected_in;
         bits_found_ff <= bits_found_in;
         code_acc_ff   <= code_acc_in;
      end
   end

endmodule

`default_nettype wire

/* dv/tb_optical_run_length_code_receiver_core.sv */
// Testbench for the optical run-length code receiver: directed frames, random traffic, back-pressure.
//
// Every accepted sample is run through a local copy of the filter and run-length decoder. A
// sample that ends a frame leaves one expected code in a queue. A separate process takes results
// from the rsp_ channel and compares them, field by field, with the oldest queued code. Registers
// are only rewritten once the queue is empty and the pipeline has had time to empty too.
module tb_optical_run_length_code_receiver_core;
   import orlc_pkg::*;

   // Cycles without any transfer before the run is declared hung. The longest legal quiet
   // stretch is the deliberate receiver hold-off below.
   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 300;
   // Input register plus state update, plus some margin.
   localparam int PIPE_DRAIN   = 4;
   localparam int WIN_LEN      = AVG_LEN_DEFAULT;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_sense_bit;
   logic                  req_frame_end;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [CODE_W-1:0]     rsp_light_code;
   logic [COUNT_W-1:0]    rsp_bit_count;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   optical_run_length_code_receiver_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sense_bit  (req_sense_bit),
      .req_frame_end  (req_frame_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_light_code (rsp_light_code),
      .rsp_bit_count  (rsp_bit_count),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // Local copy of the receiver state and of its registers.
   logic [WIN_LEN-1:0] flt_window;
   logic [POS_W-1:0]   pos_cnt;
   logic [RUN_W-1:0]   match_run;
   logic               want_level;
   logic [COUNT_W-1:0] bit_total;
   logic [CODE_W-1:0]  code_bits;
   cfg_type            cfg_shadow;

   // Codes still owed by the block, oldest first.
   result_type expected_codes[$];

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned hold_left;
   int unsigned samples_sent;
   int unsigned codes_seen;
   int unsigned err_count;
   int unsigned stall_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Predict the effect of one accepted sample. A frame end queues the code of the frame and
   // starts a new frame; the filter window carries over.
   task automatic predict_sample(input logic sense, input logic fend);
      int unsigned ones;
      logic        lvl;
      result_type  code;
      // Samples past the frame length neither enter the filter nor advance the position.
      if (pos_cnt < FRAME_LEN_DEFAULT) begin
         flt_window = {flt_window[WIN_LEN-2:0], sense};
         ones = $countones(flt_window);
         // Rounded mean, kept in integers: one when twice the sum reaches the window length.
         lvl = (2 * ones >= WIN_LEN);
         if (pos_cnt >= cfg_shadow.window_start && pos_cnt < cfg_shadow.window_end) begin
            if (lvl == want_level) begin
               if (match_run != RUN_MAX) match_run++;
            end else begin
               // A change of level restarts the run at the new level; this sample is not
               // counted as a match.
               match_run  = '0;
               want_level = lvl;
            end
            // A threshold of zero is always met, so every decoded sample takes a bit.
            if (match_run >= cfg_shadow.run_threshold) begin
               if (bit_total < CODE_W)
                  code_bits = code_bits | (CODE_W'(want_level) << (CODE_W - 1 - bit_total));
               if (bit_total != COUNT_MAX) bit_total++;
               want_level = ~want_level;
               match_run  = '0;
            end
         end
         pos_cnt++;
      end
      if (fend) begin
         code.bit_count  = bit_total;
         code.light_code = (bit_total == VALID_BITS_LO || bit_total == VALID_BITS_HI) ?
                           (code_bits & cfg_shadow.code_mask) : '0;
         expected_codes.push_back(code);
         pos_cnt    = '0;
         match_run  = '0;
         want_level = 1'b0;
         bit_total  = '0;
         code_bits  = '0;
      end
   endtask

   // Offer one sample and wait for its transfer. Valid is left high after the transfer so that
   // back-to-back samples need no gap; the next call or wait_idle lowers it.
   task automatic send_sample(input logic sense, input logic fend);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sense_bit <= sense;
      req_frame_end <= fend;
      do @(posedge clock); while (!req_ready);
      samples_sent++;
      predict_sample(sense, fend);
   endtask

   // Stop offering, let every owed code arrive, then give the last plain samples time to leave
   // the pipeline. Registers may be written after this.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_codes.size() != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_CODE_MASK:     cfg_shadow.code_mask     = data;
         CSR_RUN_THRESHOLD: cfg_shadow.run_threshold = data[RUN_W-1:0];
         CSR_WINDOW_START:  cfg_shadow.window_start  = data;
         CSR_WINDOW_END:    cfg_shadow.window_end    = data;
         default: ;
      endcase
   endtask

   // A frame built of alternating runs of the raw level, the last sample marking the frame end.
   task automatic send_run_frame(input int unsigned frame_len, input int unsigned run_lo,
                                 input int unsigned run_hi);
      logic        lvl;
      int unsigned left;
      int unsigned n;
      lvl = 1'($urandom_range(1, 0));
      n   = 0;
      while (n < frame_len) begin
         left = $urandom_range(run_hi, run_lo);
         while (left > 0 && n < frame_len) begin
            send_sample(lvl, n == frame_len - 1);
            n++;
            left--;
         end
         lvl = ~lvl;
      end
   endtask

   // Right after reset the block must report an empty frame with the default registers.
   task automatic test_reset_state();
      send_sample(1'b1, 1'b1);
   endtask

   // Threshold zero turns every decoded sample into a bit: a long window saturates the bit
   // count, a seven-sample window yields a valid masked code.
   task automatic test_zero_threshold();
      int unsigned i;
      wait_idle();
      write_csr(CSR_RUN_THRESHOLD, 8'd0);
      write_csr(CSR_WINDOW_START, 8'd0);
      write_csr(CSR_WINDOW_END, 8'd17);
      write_csr(CSR_CODE_MASK, 8'hA5);
      for (i = 0; i < 17; i++) send_sample(i[1], i == 16);
      wait_idle();
      write_csr(CSR_WINDOW_END, 8'd7);
      write_csr(CSR_CODE_MASK, 8'hFF);
      for (i = 0; i < 7; i++) send_sample(i < 3, i == 6);
   endtask

   // Window start equal to or beyond window end: nothing is decoded.
   task automatic test_empty_window();
      wait_idle();
      write_csr(CSR_WINDOW_START, 8'd1);
      write_csr(CSR_WINDOW_END, 8'd1);
      send_sample(1'b1, 1'b0);
      send_sample(1'b1, 1'b1);
      wait_idle();
      write_csr(CSR_WINDOW_START, 8'd255);
      write_csr(CSR_WINDOW_END, 8'd0);
      send_sample(1'b0, 1'b1);
   endtask

   // Frames longer than the frame length, with the widest window, the largest threshold, then a lower one.
   task automatic test_long_frames();
      wait_idle();
      write_csr(CSR_WINDOW_START, 8'd0);
      write_csr(CSR_WINDOW_END, 8'd255);
      write_csr(CSR_RUN_THRESHOLD, 8'd31);
      write_csr(CSR_CODE_MASK, 8'd0);
      // Runs long enough to saturate the run counter; the frame end lands on an ignored sample.
      send_run_frame(FRAME_LEN_DEFAULT + 9, 30, 45);
      wait_idle();
      write_csr(CSR_RUN_THRESHOLD, 8'd13);
      write_csr(CSR_CODE_MASK, 8'd255);
      send_run_frame(FRAME_LEN_DEFAULT + 2, 14, 20);
      // A frame of one sample that ends the frame at once.
      send_sample(1'b1, 1'b1);
   endtask

   // Registers for well-formed random frames: a short window sized for roughly six or seven
   // bits, so that valid codes come often. The threshold write mostly carries junk upper bits.
   task automatic pick_random_config(output int unsigned thr);
      int unsigned lo;
      int unsigned span;
      logic [CSR_DATA_W-1:0] mask;
      thr  = $urandom_range(4, 1);
      if ($urandom_range(9) == 0) thr = 0;
      lo   = $urandom_range(8, 0);
      span = 6 * (thr + 2) + $urandom_range(2 * (thr + 2), 0);
      case ($urandom_range(3))
         0:       mask = 8'h00;
         1:       mask = 8'hFF;
         default: mask = CSR_DATA_W'($urandom);
      endcase
      wait_idle();
      write_csr(CSR_RUN_THRESHOLD, {3'($urandom_range(7, 0)), thr[RUN_W-1:0]});
      write_csr(CSR_WINDOW_START, CSR_DATA_W'(lo));
      write_csr(CSR_WINDOW_END, CSR_DATA_W'(lo + span));
      write_csr(CSR_CODE_MASK, mask);
   endtask

   // Mostly well-formed frames, with some noise frames of random bits and random length.
   task automatic test_random_traffic(input int unsigned n_samples);
      int unsigned start_samples;
      int unsigned start_codes;
      int unsigned frames;
      int unsigned thr;
      int unsigned i;
      int unsigned len;
      start_samples = samples_sent;
      start_codes   = codes_seen;
      frames        = 0;
      thr           = 0;
      while (samples_sent - start_samples < n_samples || codes_seen - start_codes < 15) begin
         if (frames % 6 == 0) pick_random_config(thr);
         if ($urandom_range(3) != 0) begin
            send_run_frame(cfg_shadow.window_end + $urandom_range(5, 0), thr + 1, thr + 3);
         end else begin
            len = $urandom_range(40, 1);
            for (i = 0; i < len; i++) send_sample(1'($urandom_range(1, 0)), i == len - 1);
         end
         frames++;
      end
   endtask

   // The receiver holds off for a long stretch while short frames keep coming, so a frame end
   // waits in the input register and req_ready drops. Afterwards the sender pauses until every
   // owed code has arrived before it goes on.
   task automatic test_backpressure();
      int unsigned k;
      wait_idle();
      write_csr(CSR_WINDOW_START, 8'd0);
      write_csr(CSR_WINDOW_END, 8'd4);
      write_csr(CSR_RUN_THRESHOLD, 8'd0);
      hold_left = HOLD_CYCLES;
      for (k = 0; k < 40; k++) send_run_frame($urandom_range(4, 2), 1, 2);
      req_valid <= 1'b0;
      while (expected_codes.size() != 0) @(posedge clock);
      for (k = 0; k < 10; k++) send_run_frame($urandom_range(8, 1), 1, 3);
   endtask

   // Result side: compare each result transfer with the oldest owed code, then drive ready for
   // the next edge, honoring a requested hold-off first.
   initial begin
      result_type want;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            codes_seen++;
            if (expected_codes.size() == 0) begin
               $display("%0t: unexpected result, light_code %0d bit_count %0d", $time,
                        rsp_light_code, rsp_bit_count);
               err_count++;
            end else begin
               want = expected_codes.pop_front();
               if (rsp_light_code !== want.light_code) begin
                  $display("%0t: light_code mismatch, expected %0d, actual %0d", $time,
                           want.light_code, rsp_light_code);
                  err_count++;
               end
               if (rsp_bit_count !== want.bit_count) begin
                  $display("%0t: bit_count mismatch, expected %0d, actual %0d", $time,
                           want.bit_count, rsp_bit_count);
                  err_count++;
               end
            end
         end
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog: any transfer on any channel counts as progress.
   initial begin
      stall_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
               $display("[optical_run_length_code_receiver_core] ERROR");
               $finish;
            end
         end
      end
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_sense_bit = 1'b0;
      req_frame_end = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = CSR_CODE_MASK;
      csr_wdata     = '0;
      hold_left     = 0;
      samples_sent  = 0;
      codes_seen    = 0;
      err_count     = 0;
      flt_window    = '0;
      pos_cnt       = '0;
      match_run     = '0;
      want_level    = 1'b0;
      bit_total     = '0;
      code_bits     = '0;
      cfg_shadow.code_mask     = CODE_MASK_RESET;
      cfg_shadow.run_threshold = RUN_THRESHOLD_RESET;
      cfg_shadow.window_start  = WINDOW_START_RESET;
      cfg_shadow.window_end    = WINDOW_END_RESET;
      // Sender idles often and the receiver very often in the first part of the run.
      send_idle_pct = 34;
      recv_idle_pct = 84;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_zero_threshold();
      test_empty_window();
      test_long_frames();
      test_random_traffic(400);
      // Then the other way round, then with no idling at all.
      send_idle_pct = 84;
      recv_idle_pct = 34;
      test_random_traffic(300);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(300);
      test_backpressure();

      wait_idle();
      repeat (8) @(posedge clock);
      if (err_count == 0) begin
         $display("[optical_run_length_code_receiver_core] OK");
      end else begin
         $display("[optical_run_length_code_receiver_core] ERROR");
      end
      $finish;
   end
endmodule

/* sim.f */
design/orlc_pkg.sv
design/orlc_filter.sv
design/orlc_decoder.sv
design/optical_run_length_code_receiver_core.sv
dv/tb_optical_run_length_code_receiver_core.sv
